@@ rtl/core/assert_macros.svh @@
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication under reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication under reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

@@ rtl/core/lcdseq_pkg.sv @@
package lcdseq_pkg;

    // item command codes
    localparam logic [1:0] CMD_COMMAND = 2'd0;
    localparam logic [1:0] CMD_CHAR    = 2'd1;
    localparam logic [1:0] CMD_INIT    = 2'd2;
    localparam logic [1:0] CMD_CLEAR   = 2'd3;

    // kind of byte transfer the word unit performs
    localparam logic [1:0] KIND_ZERO = 2'd0;
    localparam logic [1:0] KIND_CMD  = 2'd1;
    localparam logic [1:0] KIND_CHR  = 2'd2;

    // seven port words per byte
    localparam logic [2:0] LAST_STEP = 3'd6;

    // lcd command bytes
    localparam logic [7:0] BYTE_CLEAR = 8'h01;
    localparam logic [7:0] BYTE_LINE2 = 8'hC0;
    localparam logic [7:0] BYTE_LINE1 = 8'h80;

    // port bit masks
    localparam logic [7:0] MASK_RS_CLR = 8'hFE;
    localparam logic [7:0] MASK_E_CLR  = 8'hFB;
    localparam logic [7:0] MASK_LOW    = 8'h0F;
    localparam logic [7:0] MASK_HIGH   = 8'hF0;
    localparam logic [7:0] BIT_E       = 8'h04;
    localparam logic [7:0] BIT_RS      = 8'h01;

    // hold times in ms
    localparam logic [5:0] HOLD_NONE  = 6'd0;
    localparam logic [5:0] HOLD_CMD   = 6'd1;
    localparam logic [5:0] HOLD_CHR_E = 6'd40;
    localparam logic [5:0] HOLD_POWER = 6'd20;
    localparam logic [5:0] EXTRA_INIT = 6'd5;
    localparam logic [5:0] EXTRA_CLR  = 6'd2;

    // request from the sequencer to the word unit
    typedef struct packed {
        logic       valid;
        logic [1:0] kind;
        logic [2:0] step;
        logic [7:0] data;
        logic [5:0] extra;
        logic       last;
    } word_req_t;

    // bytes of the power-up sequence, slot 0 is the cleared port word
    function automatic logic [7:0] init_byte(input logic [2:0] slot);
        logic [7:0] b;
        case (slot)
            3'd1:    b = 8'h33;
            3'd2:    b = 8'h32;
            3'd3:    b = 8'h28;
            3'd4:    b = 8'h06;
            3'd5:    b = 8'h01;
            3'd6:    b = 8'h0F;
            3'd7:    b = 8'h02;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

@@ rtl/core/lcdseq_if.sv @@
// input item channel
interface lcdseq_item_if;
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic [7:0] value;
    logic       string_start;

    modport source (output valid, output cmd, output value, output string_start, input ready);
    modport sink (input valid, input cmd, input value, input string_start, output ready);
endinterface

// port word channel
interface lcdseq_word_if;
    logic       valid;
    logic       ready;
    logic [7:0] pin_word;
    logic [5:0] hold_ms;
    logic       last;

    modport source (output valid, output pin_word, output hold_ms, output last, input ready);
    modport sink (input valid, input pin_word, input hold_ms, input last, output ready);
endinterface

@@ rtl/core/lcdseq_word_unit.sv @@
module lcdseq_word_unit
    import lcdseq_pkg::*;
(
    input  logic [7:0] port_image,
    input  word_req_t  req,
    output logic [7:0] word,
    output logic [5:0] hold
);

    localparam logic [2:0] OP_ZERO   = 3'd0;
    localparam logic [2:0] OP_CLR_RS = 3'd1;
    localparam logic [2:0] OP_SET_RS = 3'd2;
    localparam logic [2:0] OP_SET_E  = 3'd3;
    localparam logic [2:0] OP_CLR_E  = 3'd4;
    localparam logic [2:0] OP_HI     = 3'd5;
    localparam logic [2:0] OP_LO     = 3'd6;

    logic [2:0] op;

    // pick operation and hold for this step
    always_comb
    begin
        op   = OP_ZERO;
        hold = HOLD_NONE;
        case (req.kind)
            KIND_ZERO:
            begin
                op   = OP_ZERO;
                hold = HOLD_POWER;
            end
            KIND_CMD:
            begin
                hold = (req.step == LAST_STEP) ? HOLD_CMD + req.extra : HOLD_CMD;
                case (req.step)
                    3'd0:    op = OP_CLR_RS;
                    3'd1:    op = OP_SET_E;
                    3'd2:    op = OP_HI;
                    3'd3:    op = OP_CLR_E;
                    3'd4:    op = OP_SET_E;
                    3'd5:    op = OP_LO;
                    default: op = OP_CLR_E;
                endcase
            end
            KIND_CHR:
            begin
                case (req.step)
                    3'd0:    op = OP_SET_RS;
                    3'd1:    op = OP_HI;
                    3'd2:
                    begin
                        op   = OP_SET_E;
                        hold = HOLD_CHR_E;
                    end
                    3'd3:    op = OP_CLR_E;
                    3'd4:    op = OP_LO;
                    3'd5:
                    begin
                        op   = OP_SET_E;
                        hold = HOLD_CHR_E;
                    end
                    default:
                    begin
                        op   = OP_CLR_E;
                        hold = HOLD_CHR_E;
                    end
                endcase
            end
            default:
            begin
                op   = OP_ZERO;
                hold = HOLD_NONE;
            end
        endcase
    end

    // shared mask and nibble merge
    always_comb
    begin
        case (op)
            OP_CLR_RS: word = port_image & MASK_RS_CLR;
            OP_SET_RS: word = port_image | BIT_RS;
            OP_SET_E:  word = port_image | BIT_E;
            OP_CLR_E:  word = port_image & MASK_E_CLR;
            OP_HI:     word = (port_image & MASK_LOW) | (req.data & MASK_HIGH);
            OP_LO:     word = (port_image & MASK_LOW) | {req.data[3:0], 4'b0000};
            default:   word = 8'h00;
        endcase
    end

endmodule

@@ rtl/core/lcdseq_ctrl.sv @@
module lcdseq_ctrl
    import lcdseq_pkg::*;
#(
    parameter int LINE_CHARS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    lcdseq_item_if.sink item_ch,
    input  logic        adv,
    output word_req_t   req
);

    localparam int PW = $clog2(2 * LINE_CHARS + 1);
    localparam logic [PW-1:0] LINE_POS = PW'(LINE_CHARS);
    localparam logic [PW-1:0] FULL_POS = PW'(2 * LINE_CHARS);
    localparam logic [PW-1:0] POS_ONE  = PW'(1);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    localparam logic [2:0] MODE_CMD      = 3'd0;
    localparam logic [2:0] MODE_CLEAR    = 3'd1;
    localparam logic [2:0] MODE_INIT     = 3'd2;
    localparam logic [2:0] MODE_CHR      = 3'd3;
    localparam logic [2:0] MODE_CHR_LB   = 3'd4;
    localparam logic [2:0] MODE_CHR_FULL = 3'd5;

    localparam logic [2:0] INIT_LAST_SLOT = 3'd7;

    logic          state_reg, state_next;
    logic [2:0]    mode_reg, mode_next;
    logic [2:0]    slot_reg, slot_next;
    logic [2:0]    step_reg, step_next;
    logic [7:0]    value_reg, value_next;
    logic [PW-1:0] pos_reg, pos_next;

    logic [PW-1:0] pos_start;
    logic [1:0]    kind;
    logic [7:0]    data;
    logic [5:0]    extra;
    logic          final_slot;
    logic          step_end;
    logic          accept;

    assign item_ch.ready = (state_reg == ST_IDLE);
    assign accept        = item_ch.valid && (state_reg == ST_IDLE);

    // byte to send in the current slot
    always_comb
    begin
        kind       = KIND_CMD;
        data       = value_reg;
        extra      = HOLD_NONE;
        final_slot = 1'b1;
        case (mode_reg)
            MODE_CMD:
            begin
                kind = KIND_CMD;
            end
            MODE_CLEAR:
            begin
                data  = BYTE_CLEAR;
                extra = EXTRA_CLR;
            end
            MODE_INIT:
            begin
                if (slot_reg == 3'd0)
                begin
                    kind       = KIND_ZERO;
                    final_slot = 1'b0;
                end
                else
                begin
                    data       = init_byte(slot_reg);
                    extra      = (slot_reg == 3'd1) ? EXTRA_INIT : HOLD_NONE;
                    final_slot = (slot_reg == INIT_LAST_SLOT);
                end
            end
            MODE_CHR:
            begin
                kind = KIND_CHR;
            end
            MODE_CHR_LB:
            begin
                if (slot_reg == 3'd0)
                begin
                    data       = BYTE_LINE2;
                    final_slot = 1'b0;
                end
                else
                begin
                    kind = KIND_CHR;
                end
            end
            MODE_CHR_FULL:
            begin
                if (slot_reg == 3'd0)
                begin
                    data       = BYTE_CLEAR;
                    final_slot = 1'b0;
                end
                else if (slot_reg == 3'd1)
                begin
                    data       = BYTE_LINE1;
                    final_slot = 1'b0;
                end
                else
                begin
                    kind = KIND_CHR;
                end
            end
            default:
            begin
                kind = KIND_CMD;
            end
        endcase
    end

    assign step_end = (kind == KIND_ZERO) || (step_reg == LAST_STEP);

    assign req.valid = (state_reg == ST_RUN);
    assign req.kind  = kind;
    assign req.step  = step_reg;
    assign req.data  = data;
    assign req.extra = extra;
    assign req.last  = final_slot && step_end;

    assign pos_start = item_ch.string_start ? '0 : pos_reg;

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        mode_next  = mode_reg;
        slot_next  = slot_reg;
        step_next  = step_reg;
        value_next = value_reg;
        pos_next   = pos_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_RUN;
                    slot_next  = 3'd0;
                    step_next  = 3'd0;
                    value_next = item_ch.value;
                    case (item_ch.cmd)
                        CMD_COMMAND: mode_next = MODE_CMD;
                        CMD_INIT:    mode_next = MODE_INIT;
                        CMD_CLEAR:   mode_next = MODE_CLEAR;
                        default:
                        begin
                            if (pos_start == LINE_POS)
                            begin
                                mode_next = MODE_CHR_LB;
                                pos_next  = pos_start + POS_ONE;
                            end
                            else if (pos_start >= FULL_POS)
                            begin
                                mode_next = MODE_CHR_FULL;
                                pos_next  = POS_ONE;
                            end
                            else
                            begin
                                mode_next = MODE_CHR;
                                pos_next  = pos_start + POS_ONE;
                            end
                        end
                    endcase
                end
            end
            default:
            begin
                if (adv)
                begin
                    if (step_end)
                    begin
                        step_next = 3'd0;
                        if (final_slot)
                        begin
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            slot_next = slot_reg + 3'd1;
                        end
                    end
                    else
                    begin
                        step_next = step_reg + 3'd1;
                    end
                end
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            mode_reg  <= MODE_CMD;
            slot_reg  <= 3'd0;
            step_reg  <= 3'd0;
            pos_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
            slot_reg  <= slot_next;
            step_reg  <= step_next;
            pos_reg   <= pos_next;
        end
    end

    // payload register
    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

@@ rtl/core/char_lcd_nibble_write_sequencer_top.sv @@
// Character LCD 4-bit bus sequencer. Each accepted item (command byte, display
// character, power-up init or clear) is expanded into port words with RS on
// bit 0, enable on bit 2 and the data nibble on bits 7:4, each paired with its
// hold time in ms and a last flag on the final word of the item. One shared
// word unit produces one port word per cycle from the port image while the
// output register is empty or being drained. A command, clear or plain
// character makes 7 words, a character that starts the second line 14, one
// that wraps a full screen 21 (clear and home first) and init 50. The item
// channel is ready only while no item is in progress, so a new item is not
// taken before the last word of the current one is produced; the next item
// can be taken while the final word still sits in the output register.
`include "assert_macros.svh"

module char_lcd_nibble_write_sequencer_top
    import lcdseq_pkg::*;
#(
    parameter int LINE_CHARS = 16
)
(
    input  logic          clk,
    input  logic          rst_n,
    lcdseq_item_if.sink   item_ch,
    lcdseq_word_if.source word_ch
);

    word_req_t  req;
    logic [7:0] word;
    logic [5:0] hold;
    logic       adv;

    logic [7:0] port_image_reg;
    logic       out_valid_reg;
    logic [7:0] pin_reg;
    logic [5:0] hold_reg;
    logic       last_reg;

    // sequencer
    lcdseq_ctrl #(
        .LINE_CHARS (LINE_CHARS)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .item_ch (item_ch),
        .adv     (adv),
        .req     (req)
    );

    // shared port word unit
    lcdseq_word_unit u_word (
        .port_image (port_image_reg),
        .req        (req),
        .word       (word),
        .hold       (hold)
    );

    // advance when the output register is empty or being drained
    assign adv = req.valid && (!out_valid_reg || word_ch.ready);

    // port image and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            port_image_reg <= 8'h00;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (adv)
            begin
                port_image_reg <= word;
                out_valid_reg  <= 1'b1;
            end
            else if (word_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pin_reg  <= word;
            hold_reg <= hold;
            last_reg <= req.last;
        end
    end

    assign word_ch.valid    = out_valid_reg;
    assign word_ch.pin_word = pin_reg;
    assign word_ch.hold_ms  = hold_reg;
    assign word_ch.last     = last_reg;

    // checks
    `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, item_ch.valid && item_ch.ready, !item_ch.ready)
    `ASSERT_IMPLIES(a_hold_range, clk, rst_n, word_ch.valid, word_ch.hold_ms <= 6'd40)
    `ASSERT_IMPLIES(a_last_enable_low, clk, rst_n, word_ch.valid && word_ch.last, !word_ch.pin_word[2])

endmodule

@@ tb/sv/char_lcd_nibble_write_sequencer_top_test.sv @@
module char_lcd_nibble_write_sequencer_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import lcdseq_pkg::*;

    localparam int LINE_CHARS  = 16;
    localparam int ITEM_COUNT  = 410;
    localparam int IDLE_PCT    = 23;
    localparam int QUIET_FROM  = 1500;
    localparam int QUIET_TO    = 3500;
    localparam int HOLDOFF_AT  = 800;
    localparam int HOLDOFF_LEN = 300;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_WAIT  = 20;

    // power-up command bytes, sent in order from the top element down
    localparam logic [6:0][7:0] POWER_UP_BYTES =
        {8'h33, 8'h32, 8'h28, 8'h06, BYTE_CLEAR, 8'h0F, 8'h02};

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] value;
        logic       string_start;
    } lcd_item_t;

    typedef struct packed {
        logic [7:0] pin_word;
        logic [5:0] hold_ms;
        logic       last;
    } port_word_t;

    logic clk;
    logic rst_n;

    lcdseq_item_if item_bus();
    lcdseq_word_if word_bus();

    char_lcd_nibble_write_sequencer_top #(.LINE_CHARS(LINE_CHARS)) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .item_ch (item_bus),
        .word_ch (word_bus)
    );

    lcd_item_t  pending_items[$];
    port_word_t expected_words[$];
    port_word_t item_words[$];

    // shadow of the lcd port and the cursor position
    logic [7:0] lcd_port   = 8'h00;
    logic [7:0] lcd_column = 8'h00;

    int errors       = 0;
    int items_sent   = 0;
    int words_seen   = 0;
    int inits_sent   = 0;
    int line_breaks  = 0;
    int screen_wraps = 0;
    int drv_cycle;
    int mon_cycle;
    int holdoff_left;
    bit holdoff_done;
    int stall_cycles;

    // port word shadow updates
    task automatic put_word(input logic [7:0] w, input logic [5:0] hold);
        port_word_t pw;
        lcd_port    = w;
        pw.pin_word = w;
        pw.hold_ms  = hold;
        pw.last     = 1'b0;
        item_words.push_back(pw);
    endtask

    task automatic put_command(input logic [7:0] c);
        put_word(lcd_port & MASK_RS_CLR, HOLD_CMD);
        put_word(lcd_port | BIT_E, HOLD_CMD);
        put_word((lcd_port & MASK_LOW) | (c & MASK_HIGH), HOLD_CMD);
        put_word(lcd_port & MASK_E_CLR, HOLD_CMD);
        put_word(lcd_port | BIT_E, HOLD_CMD);
        put_word((lcd_port & MASK_LOW) | {c[3:0], 4'h0}, HOLD_CMD);
        put_word(lcd_port & MASK_E_CLR, HOLD_CMD);
    endtask

    task automatic put_character(input logic [7:0] d);
        put_word(lcd_port | BIT_RS, HOLD_NONE);
        put_word((lcd_port & MASK_LOW) | (d & MASK_HIGH), HOLD_NONE);
        put_word(lcd_port | BIT_E, HOLD_CHR_E);
        put_word(lcd_port & MASK_E_CLR, HOLD_NONE);
        put_word((lcd_port & MASK_LOW) | {d[3:0], 4'h0}, HOLD_NONE);
        put_word(lcd_port | BIT_E, HOLD_CHR_E);
        put_word(lcd_port & MASK_E_CLR, HOLD_CHR_E);
    endtask

    task automatic stretch_last_hold(input logic [5:0] extra);
        item_words[item_words.size() - 1].hold_ms =
            item_words[item_words.size() - 1].hold_ms + extra;
    endtask

    // expand one accepted item into the port words it should produce
    task automatic expand_lcd_item(input lcd_item_t it);
        int i;
        item_words.delete();
        case (it.cmd)
            CMD_COMMAND: put_command(it.value);
            CMD_CHAR:
            begin
                if (it.string_start)
                    lcd_column = 8'd0;
                if (lcd_column == LINE_CHARS)
                begin
                    put_command(BYTE_LINE2);
                    line_breaks++;
                end
                else if (lcd_column >= 2 * LINE_CHARS)
                begin
                    put_command(BYTE_CLEAR);
                    put_command(BYTE_LINE1);
                    lcd_column = 8'd0;
                    screen_wraps++;
                end
                put_character(it.value);
                lcd_column = lcd_column + 8'd1;
            end
            CMD_INIT:
            begin
                put_word(8'h00, HOLD_POWER);
                put_command(POWER_UP_BYTES[6]);
                stretch_last_hold(EXTRA_INIT);
                for (i = 5; i >= 0; i--)
                    put_command(POWER_UP_BYTES[i]);
                inits_sent++;
            end
            default:
            begin
                put_command(BYTE_CLEAR);
                stretch_last_hold(EXTRA_CLR);
            end
        endcase
        item_words[item_words.size() - 1].last = 1'b1;
        foreach (item_words[i])
            expected_words.push_back(item_words[i]);
    endtask

    // stimulus helpers
    task automatic add_item(input logic [1:0] cmd, input logic [7:0] value,
                            input logic string_start);
        lcd_item_t it;
        it.cmd          = cmd;
        it.value        = value;
        it.string_start = string_start;
        pending_items.push_back(it);
    endtask

    task automatic add_string(input int len, input bit restart);
        int k;
        for (k = 0; k < len; k++)
            add_item(CMD_CHAR, 8'($urandom_range(255)), restart && (k == 0));
    endtask

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // item driver
    always @(posedge clk or negedge rst_n)
    begin : item_driver
        lcd_item_t taken;
        lcd_item_t next_item;
        bit        quiet;
        if (!rst_n)
        begin
            item_bus.valid        <= 1'b0;
            item_bus.cmd          <= CMD_COMMAND;
            item_bus.value        <= 8'h00;
            item_bus.string_start <= 1'b0;
            drv_cycle             <= 0;
        end
        else
        begin
            drv_cycle <= drv_cycle + 1;
            if (item_bus.valid && item_bus.ready)
            begin
                taken.cmd          = item_bus.cmd;
                taken.value        = item_bus.value;
                taken.string_start = item_bus.string_start;
                expand_lcd_item(taken);
                items_sent++;
            end
            if (!item_bus.valid || item_bus.ready)
            begin
                quiet = (drv_cycle >= QUIET_FROM) && (drv_cycle < QUIET_TO);
                if (pending_items.size() > 0 && (quiet || $urandom_range(99) >= IDLE_PCT))
                begin
                    next_item = pending_items.pop_front();
                    item_bus.valid        <= 1'b1;
                    item_bus.cmd          <= next_item.cmd;
                    item_bus.value        <= next_item.value;
                    item_bus.string_start <= next_item.string_start;
                end
                else
                begin
                    // idle with junk on the payload
                    item_bus.valid        <= 1'b0;
                    item_bus.cmd          <= 2'($urandom_range(3));
                    item_bus.value        <= 8'($urandom_range(255));
                    item_bus.string_start <= 1'($urandom_range(1));
                end
            end
        end
    end

    // port word monitor and checker
    always @(posedge clk or negedge rst_n)
    begin : word_monitor
        port_word_t want;
        bit         quiet;
        if (!rst_n)
        begin
            word_bus.ready <= 1'b0;
            mon_cycle      <= 0;
            holdoff_left   <= 0;
            holdoff_done   <= 1'b0;
        end
        else
        begin
            mon_cycle <= mon_cycle + 1;
            if (word_bus.valid && word_bus.ready)
            begin
                words_seen++;
                if (expected_words.size() == 0)
                begin
                    $display("%0t: unexpected port word %02h hold %0d last %0b", $time,
                             word_bus.pin_word, word_bus.hold_ms, word_bus.last);
                    errors++;
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (word_bus.pin_word !== want.pin_word || word_bus.hold_ms !== want.hold_ms
                        || word_bus.last !== want.last)
                    begin
                        $display("%0t: port word mismatch: expected %02h/%0d/%0b actual %02h/%0d/%0b",
                                 $time, want.pin_word, want.hold_ms, want.last,
                                 word_bus.pin_word, word_bus.hold_ms, word_bus.last);
                        errors++;
                    end
                end
            end
            // one long hold-off so the block backs up into the item channel
            quiet = (mon_cycle >= QUIET_FROM) && (mon_cycle < QUIET_TO);
            if (holdoff_left > 0)
            begin
                holdoff_left   <= holdoff_left - 1;
                word_bus.ready <= 1'b0;
            end
            else if (!holdoff_done && mon_cycle >= HOLDOFF_AT)
            begin
                holdoff_left   <= HOLDOFF_LEN;
                holdoff_done   <= 1'b1;
                word_bus.ready <= 1'b0;
            end
            else
                word_bus.ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // watchdog on cycles with no progress on either channel
    always @(posedge clk)
    begin
        if (!rst_n)
            stall_cycles <= 0;
        else
        begin
            if ((item_bus.valid && item_bus.ready) || (word_bus.valid && word_bus.ready))
                stall_cycles <= 0;
            else if (stall_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
                $display("Regression FAIL");
                $finish;
            end
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

    // stimulus, reset and end of run
    initial
    begin : run_control
        int pick;
        rst_n = 1'b0;

        // directed: every item kind, byte extremes, character zero, restarts
        add_item(CMD_INIT, 8'hFF, 1'b1);
        add_item(CMD_COMMAND, 8'h00, 1'b0);
        add_item(CMD_COMMAND, 8'hFF, 1'b0);
        add_item(CMD_COMMAND, 8'h5A, 1'b1);
        add_item(CMD_CLEAR, 8'hA5, 1'b0);
        add_item(CMD_CHAR, 8'h00, 1'b1);
        add_item(CMD_CHAR, 8'hFF, 1'b0);
        add_item(CMD_CHAR, 8'hA5, 1'b1);
        add_item(CMD_COMMAND, 8'h0C, 1'b0);
        add_item(CMD_CHAR, 8'h3C, 1'b0);
        add_item(CMD_INIT, 8'h00, 1'b0);
        add_item(CMD_CLEAR, 8'hFF, 1'b1);

        // random: mostly strings, some long enough to break lines and wrap
        add_string(40, 1'b1);
        while (pending_items.size() < ITEM_COUNT)
        begin
            pick = $urandom_range(99);
            if (pick < 50)
                add_string(($urandom_range(99) < 30) ? $urandom_range(30, 40)
                                                     : $urandom_range(1, 20), 1'b1);
            else if (pick < 62)
                add_string($urandom_range(1, 20), 1'b0);
            else if (pick < 82)
                add_item(CMD_COMMAND, 8'($urandom_range(255)), 1'($urandom_range(1)));
            else if (pick < 94)
                add_item(CMD_CLEAR, 8'($urandom_range(255)), 1'($urandom_range(1)));
            else
                add_item(CMD_INIT, 8'($urandom_range(255)), 1'($urandom_range(1)));
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_items.size() != 0 || item_bus.valid || expected_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (expected_words.size() != 0)
        begin
            $display("%0t: %0d port words never arrived", $time, expected_words.size());
            errors++;
        end
        $display("%0d items sent (%0d inits), %0d port words checked",
                 items_sent, inits_sent, words_seen);
        $display("%0d second-line breaks, %0d full-screen wraps, %0d errors",
                 line_breaks, screen_wraps, errors);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
